>>> rtl/pfc_pkg.sv
package pfc_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_SLASH = 8'h2f;

    typedef enum logic [2:0] {
        OP_LDR = 3'd0,
        OP_ADD = 3'd1,
        OP_SUB = 3'd2,
        OP_MUL = 3'd3,
        OP_DIV = 3'd4,
        OP_STR = 3'd5
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } t_status;

    typedef enum logic {
        K_OPND = 1'b0,
        K_OPER = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_TOP,
        S_LDR_TOP,
        S_LDR_BELOW,
        S_ARITH,
        S_STR
    } t_state;

    typedef struct packed {
        logic [7:0] token;
        logic       is_final;
    } t_item;

    typedef struct packed {
        t_opcode    opcode;
        logic       first_is_temp;
        logic [7:0] first_operand;
        logic       second_is_temp;
        logic [7:0] second_operand;
        t_status    status;
        logic       run_end;
    } t_result;

    // classified token as it travels from front to back
    typedef struct packed {
        t_kind      kind;
        t_opcode    op;
        logic [7:0] token;
        logic       is_final;
    } t_cmd;

endpackage

>>> rtl/pfc_front.sv
module pfc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  pfc_pkg::t_item i_item,
    output logic           o_cmd_valid,
    output pfc_pkg::t_cmd  o_cmd,
    input  logic           i_cmd_pop
);
    import pfc_pkg::*;

    localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd            r_q [QUEUE_DEPTH];
    logic [QP_W-1:0] r_wp, n_wp;
    logic [QP_W-1:0] r_rp, n_rp;
    logic [QC_W-1:0] r_qcnt, n_qcnt;
    t_cmd            cls;
    logic            is_break;
    logic            wr_en;
    logic            rd_en;

    always_comb begin
        cls          = '0;
        cls.token    = i_item.token;
        cls.is_final = i_item.is_final;
        cls.kind     = K_OPER;
        case (i_item.token)
            CH_PLUS:  cls.op = OP_ADD;
            CH_MINUS: cls.op = OP_SUB;
            CH_STAR:  cls.op = OP_MUL;
            CH_SLASH: cls.op = OP_DIV;
            default: begin
                cls.op   = OP_LDR;
                cls.kind = K_OPND;
            end
        endcase
    end

    assign is_break    = (i_item.token == CH_LF) || (i_item.token == CH_CR);
    assign o_full      = (r_qcnt == QC_W'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_qcnt != '0);
    assign o_cmd       = r_q[r_rp];
    // line breaks are taken and dropped here
    assign wr_en       = i_push && !o_full && !is_break;
    assign rd_en       = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_wp   = r_wp;
        n_rp   = r_rp;
        n_qcnt = r_qcnt;
        if (wr_en) begin
            n_wp = (r_wp == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QP_W'(1);
        end
        if (rd_en) begin
            n_rp = (r_rp == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QP_W'(1);
        end
        if (wr_en && !rd_en) begin
            n_qcnt = r_qcnt + QC_W'(1);
        end else if (!wr_en && rd_en) begin
            n_qcnt = r_qcnt - QC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_qcnt <= '0;
        end else begin
            r_wp   <= n_wp;
            r_rp   <= n_rp;
            r_qcnt <= n_qcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule

>>> rtl/pfc_back.sv
module pfc_back #(
    parameter int STACK_DEPTH = pfc_pkg::STACK_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  pfc_pkg::t_cmd    i_cmd,
    output logic             o_cmd_pop,
    output logic             o_res_valid,
    output pfc_pkg::t_result o_res,
    input  logic             i_res_pop
);
    import pfc_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_temp, n_temp;
    logic [8:0]       r_stack [STACK_DEPTH];
    logic [8:0]       r_rdata;
    logic [8:0]       r_top;
    logic [8:0]       r_below;
    t_opcode          r_op;
    logic             r_final;
    logic             r_out_valid;
    t_result          r_out;

    logic             slot_free;
    logic             cnt_lt2;
    logic             stk_full;
    logic             emit;
    t_result          rec;
    logic             wr_en;
    logic [8:0]       wr_data;
    logic [IDX_W-1:0] wr_addr;
    logic [CNT_W-1:0] rd_cnt;
    logic [IDX_W-1:0] rd_addr;

    assign slot_free   = !r_out_valid || i_res_pop;
    assign cnt_lt2     = r_count < CNT_W'(2);
    assign stk_full    = r_count == CNT_W'(STACK_DEPTH);
    assign wr_addr     = r_count[IDX_W-1:0];
    assign rd_addr     = rd_cnt[IDX_W-1:0];
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && slot_free && i_cmd.kind == K_OPER && !cnt_lt2) begin
                    n_state = S_RD_TOP;
                end
            end
            S_RD_TOP:    n_state = S_LDR_TOP;
            S_LDR_TOP:   if (slot_free) n_state = S_LDR_BELOW;
            S_LDR_BELOW: if (slot_free) n_state = S_ARITH;
            S_ARITH: begin
                if (slot_free) begin
                    n_state = r_final ? S_IDLE : S_STR;
                end
            end
            S_STR:       if (slot_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop = 1'b0;
        emit      = 1'b0;
        rec       = '0;
        wr_en     = 1'b0;
        wr_data   = {1'b0, i_cmd.token};
        // below-top entry by default; top entry in the idle state, where the command is taken
        rd_cnt    = r_count - CNT_W'(2);
        n_count   = r_count;
        n_temp    = r_temp;
        case (r_state)
            S_IDLE: begin
                o_cmd_pop = i_cmd_valid && slot_free;
                rd_cnt    = r_count - CNT_W'(1);
                if (o_cmd_pop) begin
                    if (i_cmd.kind == K_OPND) begin
                        if (stk_full) begin
                            emit        = 1'b1;
                            rec.status  = ST_OVER;
                            rec.run_end = 1'b1;
                        end else begin
                            wr_en   = 1'b1;
                            n_count = r_count + CNT_W'(1);
                        end
                    end else if (cnt_lt2) begin
                        emit        = 1'b1;
                        rec.status  = ST_UNDER;
                        rec.run_end = 1'b1;
                    end
                end
            end
            S_LDR_TOP: begin
                emit              = slot_free;
                rec.opcode        = OP_LDR;
                rec.first_is_temp = r_top[8];
                rec.first_operand = r_top[7:0];
                if (slot_free) begin
                    n_count = r_count - CNT_W'(2);
                    n_temp  = r_temp + 8'd1;
                end
            end
            S_LDR_BELOW: begin
                emit              = slot_free;
                rec.opcode        = OP_LDR;
                rec.first_is_temp = r_below[8];
                rec.first_operand = r_below[7:0];
            end
            S_ARITH: begin
                emit               = slot_free;
                rec.opcode         = r_op;
                rec.first_is_temp  = r_top[8];
                rec.first_operand  = r_top[7:0];
                rec.second_is_temp = r_below[8];
                rec.second_operand = r_below[7:0];
                rec.run_end        = r_final;
            end
            S_STR: begin
                emit              = slot_free;
                rec.opcode        = OP_STR;
                rec.first_is_temp = 1'b1;
                rec.first_operand = r_temp;
                rec.run_end       = 1'b1;
                wr_data           = {1'b1, r_temp};
                if (slot_free) begin
                    wr_en   = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_temp      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_temp  <= n_temp;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_res_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= rec;
        end
        if (o_cmd_pop) begin
            r_op    <= i_cmd.op;
            r_final <= i_cmd.is_final;
        end
        if (r_state == S_RD_TOP) begin
            r_top <= r_rdata;
        end
        // read address holds on the entry below while waiting here
        if (r_state == S_LDR_TOP) begin
            r_below <= r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_stack[wr_addr] <= wr_data;
        end
        r_rdata <= r_stack[rd_addr];
    end

endmodule

>>> rtl/postfix_to_load_store_codegen_unit.sv
// An item passes the input queue register; an operator's first record is registered in
// the load-top state, after read-top. Operand and error items are taken in idle; an
// operator steps read-top, load-top, load-below, arith and store (not when final), paced
// by the single stack read port and one record per cycle out while the result is free.
// Reset (synchronous, active low) empties the queue and result register and clears the
// stack count and temp counter; stack entries are not cleared.
module postfix_to_load_store_codegen_unit #(
    parameter int STACK_DEPTH = pfc_pkg::STACK_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  pfc_pkg::t_item   i_item,
    output logic             empty,
    input  logic             pop,
    output pfc_pkg::t_result o_result
);
    import pfc_pkg::*;

    logic    cmd_valid;
    t_cmd    cmd;
    logic    cmd_pop;
    logic    res_valid;

    pfc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    pfc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_valid (res_valid),
        .o_res       (o_result),
        .i_res_pop   (pop)
    );

    assign empty = !res_valid;

endmodule

>>> rtl/pfc_checker.sv
module pfc_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             pop,
    input logic             empty,
    input pfc_pkg::t_result o_result
);
    import pfc_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result))
        else $error("result changed while stalled");

    a_err_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.status != ST_OK |->
            o_result.opcode == OP_LDR && o_result.first_operand == 8'd0 &&
            !o_result.first_is_temp && o_result.second_operand == 8'd0 &&
            !o_result.second_is_temp && o_result.run_end)
        else $error("malformed error record");

    a_str_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.opcode == OP_STR |->
            o_result.first_is_temp && o_result.run_end && o_result.status == ST_OK)
        else $error("malformed store record");

    a_ldr_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.opcode == OP_LDR && o_result.status == ST_OK |->
            !o_result.run_end && !o_result.second_is_temp &&
            o_result.second_operand == 8'd0)
        else $error("malformed load record");

endmodule

bind postfix_to_load_store_codegen_unit pfc_checker u_pfc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .pop      (pop),
    .empty    (empty),
    .o_result (o_result)
);
